@@ rtl/core/b64d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SEXTET,
    KIND_PAD,
    KIND_INVALID
  } b64d_kind_t;

  typedef struct packed {
    b64d_kind_t kind;
    logic [5:0] sextet;
    logic       last;
  } b64d_entry_t;

  function automatic b64d_entry_t classify(input logic [7:0] c, input logic present,
                                           input logic last);
    b64d_entry_t e;
    e.last   = last;
    e.sextet = 6'd0;
    e.kind   = KIND_INVALID;
    if (!present) begin
      e.kind = KIND_NONE;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      e.kind   = KIND_SEXTET;
      e.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      e.kind   = KIND_SEXTET;
      e.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      e.kind   = KIND_SEXTET;
      e.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      e.kind   = KIND_SEXTET;
      e.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      e.kind   = KIND_SEXTET;
      e.sextet = 6'd63;
    end else if (c == PAD_CHAR) begin
      e.kind = KIND_PAD;
    end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
      e.kind = KIND_NONE;
    end
    return e;
  endfunction

endpackage

@@ rtl/core/b64d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and pushes the words that matter.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char,
  input  logic                  char_present,
  input  logic                  end_of_text,
  input  logic                  q_full,
  output logic                  push,
  output b64d_pkg::b64d_entry_t push_data
);

  assign push_data = b64d_pkg::classify(in_char, char_present, end_of_text);
  assign in_ready  = !q_full;
  // Whitespace and bare markers without an end have no effect and are dropped.
  assign push      = in_valid && !q_full &&
                     (push_data.kind != b64d_pkg::KIND_NONE || push_data.last);

endmodule

@@ rtl/core/b64d_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Small register queue between the classifier and the decode back end.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64d_pkg::b64d_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  q_valid,
  output b64d_pkg::b64d_entry_t q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::b64d_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/b64d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Bit accumulator, stop and error tracking, and the output register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  b64d_pkg::b64d_entry_t q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  byte_valid,
  output logic                  end_of_result,
  output logic                  status
);

  logic [12:0] acc;
  logic [2:0]  cnt;
  logic        stopped;
  logic        error_seen;
  logic        pend_close;

  logic [12:0] acc_next;
  logic [2:0]  cnt_next;
  logic        stopped_next;
  logic        error_next;
  logic [3:0]  cnt6;
  logic        byte_out;
  logic [12:0] shifted;
  logic        out_free;
  logic        close_load;

  assign out_free = !out_valid || out_ready;
  assign pop      = q_valid && out_free && !pend_close;

  always_comb begin
    acc_next     = acc;
    cnt_next     = cnt;
    stopped_next = stopped;
    error_next   = error_seen;
    byte_out     = 1'b0;
    cnt6         = {1'b0, cnt} + 4'd6;
    shifted      = '0;
    if (!stopped) begin
      unique case (q_data.kind)
        b64d_pkg::KIND_SEXTET: begin
          acc_next = {acc[6:0], q_data.sextet};
          cnt_next = cnt6[2:0];
          byte_out = cnt6[3];
          shifted  = acc_next >> cnt_next;
        end
        b64d_pkg::KIND_PAD: begin
          stopped_next = 1'b1;
        end
        b64d_pkg::KIND_INVALID: begin
          stopped_next = 1'b1;
          error_next   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign close_load = out_free &&
                      (pend_close || (pop && q_data.last && !byte_out));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      stopped    <= 1'b0;
      error_seen <= 1'b0;
      pend_close <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (close_load || (pop && byte_out)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (close_load) begin
        out_byte      <= 8'd0;
        byte_valid    <= 1'b0;
        end_of_result <= 1'b1;
        status        <= pend_close ? error_seen : error_next;
        pend_close    <= 1'b0;
        acc           <= '0;
        cnt           <= '0;
        stopped       <= 1'b0;
        error_seen    <= 1'b0;
      end else if (pop) begin
        acc        <= acc_next;
        cnt        <= cnt_next;
        stopped    <= stopped_next;
        error_seen <= error_next;
        if (byte_out) begin
          out_byte      <= shifted[7:0];
          byte_valid    <= 1'b1;
          end_of_result <= 1'b0;
          status        <= 1'b0;
          pend_close    <= q_data.last;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_even: assert property (@(posedge clk) disable iff (rst) !cnt[0])
    else $error("bit count is odd");
  a_pend_byte: assert property (@(posedge clk) disable iff (rst)
    pend_close |-> (out_valid && byte_valid))
    else $error("pending close without a byte in the output register");
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid ^ end_of_result))
    else $error("result is neither a byte nor a close, or both");
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> !status)
    else $error("status set on a byte result");
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    close_load |=> (cnt == 3'd0 && !stopped && !error_seen && !pend_close))
    else $error("state not cleared after closing result");
`endif

endmodule

@@ rtl/core/base64_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 text decoder, standard alphabet, one character per word.
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle while the queue is not full. A
// character is classified in the cycle it is accepted and written to a short
// queue; the back end takes one queued word per cycle while the output register
// is free and no close is pending, into the bit accumulator and the output
// register. The back end gives out one result per cycle unless the output
// stalls: a word that completes a byte and ends the text holds the back end
// for the byte and the closing result, and the queue absorbs that hold and any
// output stall until it fills. Whitespace is dropped at the front, '=' stops
// decoding, and an invalid character stops decoding with status 1 on the
// closing result; on status 1 the bytes of that text are to be discarded.
module base64_stream_decoder_top #(
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       char_present,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_result,
  output logic       status
);

  logic                  q_full;
  logic                  push;
  b64d_pkg::b64d_entry_t push_data;
  logic                  pop;
  logic                  q_valid;
  b64d_pkg::b64d_entry_t q_data;

  b64d_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .char_present (char_present),
    .end_of_text  (end_of_text),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  b64d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_result (end_of_result),
    .status        (status)
  );

endmodule

@@ dv/tb_base64_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_top
// Self-checking testbench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// Characters are sent one word at a time over the input handshake. Each
// accepted word runs through a local decoder that tracks the pending bits, the
// stop flag and the error flag, and queues the byte and closing results it
// expects. Every result taken from the output is checked field by field against
// the oldest queued expectation. A directed pass covers whitespace, padding,
// invalid characters, bare end markers and empty texts; random passes follow
// with mostly clean texts, a stretch without idling, and noisy texts. Both
// sides idle and stall at random.
module tb_base64_stream_decoder_top;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam string      ALPHABET   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] data;
    logic       bv;
    logic       eor;
    logic       st;
  } decoded_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] in_char       = 8'h00;
  logic       char_present  = 1'b0;
  logic       end_of_text   = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_result;
  logic       status;

  decoded_t   expected_results[$];
  int         sextet_table[256];
  logic [12:0] pend_bits;
  logic [2:0]  pend_count;
  logic        dec_stopped;
  logic        dec_error;
  int          error_count = 0;
  int          words_sent  = 0;
  int          idle_pct    = 30;
  int          stall_pct   = 30;

  base64_stream_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char       (in_char),
    .char_present  (char_present),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_result (end_of_result),
    .status        (status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic add_expected(input decoded_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_decode(input logic [7:0] c, input logic p, input logic e);
    decoded_t    r;
    int          sx;
    logic [12:0] nbits;
    logic [3:0]  ncount;
    if (p && !dec_stopped) begin
      sx = sextet_table[c];
      if (c == b64d_pkg::PAD_CHAR) begin
        dec_stopped = 1'b1;
      end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
      end else if (sx < 0) begin
        dec_error   = 1'b1;
        dec_stopped = 1'b1;
      end else begin
        nbits  = {pend_bits[6:0], 6'(sx)};
        ncount = 4'(pend_count) + 4'd6;
        if (ncount >= 4'd8) begin
          ncount = ncount - 4'd8;
          r.data = 8'(nbits >> ncount);
          r.bv   = 1'b1;
          r.eor  = 1'b0;
          r.st   = 1'b0;
          add_expected(r);
        end
        pend_bits  = nbits;
        pend_count = 3'(ncount);
      end
    end
    if (e) begin
      r.data = 8'h00;
      r.bv   = 1'b0;
      r.eor  = 1'b1;
      r.st   = dec_error;
      add_expected(r);
      pend_bits   = '0;
      pend_count  = '0;
      dec_stopped = 1'b0;
      dec_error   = 1'b0;
    end
  endtask

  task automatic send_word(input logic [7:0] c, input logic p, input logic e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_char      <= c;
    char_present <= p;
    end_of_text  <= e;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_decode(c, p, e);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_text_char(input int noise_pct);
    int r;
    r = $urandom_range(99);
    if (r < noise_pct) return 8'($urandom_range(255));
    if (r < noise_pct + 8) begin
      case ($urandom_range(3))
        0: return CHAR_SPACE;
        1: return CHAR_TAB;
        2: return CHAR_CR;
        default: return CHAR_LF;
      endcase
    end
    return ALPHABET[$urandom_range(63)];
  endfunction

  task automatic send_text(input int len, input int noise_pct);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(pick_text_char(noise_pct), 1'b1, 1'b0);
    end
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 2)) send_word(b64d_pkg::PAD_CHAR, 1'b1, 1'b0);
      if ($urandom_range(1)) send_word(pick_text_char(noise_pct), 1'b1, 1'b0);
    end
    if ($urandom_range(1)) begin
      send_word(pick_text_char(noise_pct), 1'b1, 1'b1);
    end else begin
      send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  task automatic test_directed_cases();
    send_word(8'h00, 1'b0, 1'b1);
    send_word("T", 1'b1, 1'b0);
    send_word(CHAR_SPACE, 1'b1, 1'b0);
    send_word("W", 1'b1, 1'b0);
    send_word(CHAR_TAB, 1'b1, 1'b0);
    send_word("F", 1'b1, 1'b0);
    send_word(CHAR_CR, 1'b1, 1'b0);
    send_word(CHAR_LF, 1'b1, 1'b0);
    send_word("u", 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word("Q", 1'b1, 1'b0);
    send_word("Q", 1'b1, 1'b0);
    send_word(b64d_pkg::PAD_CHAR, 1'b1, 1'b0);
    send_word("A", 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word("A", 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word("B", 1'b1, 1'b0);
    send_word("C", 1'b1, 1'b1);
    send_word("+", 1'b1, 1'b0);
    send_word("/", 1'b1, 1'b0);
    send_word("z", 1'b1, 1'b0);
    send_word("9", 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_random_texts(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(99) < 10) send_text($urandom_range(20, 40), 2);
      else send_text($urandom_range(0, 12), 2);
    end
  endtask

  task automatic test_no_idle_stretch(input int count);
    int target;
    target    = words_sent + count;
    idle_pct  = 0;
    stall_pct = 0;
    while (words_sent < target) send_text($urandom_range(0, 12), 2);
    idle_pct  = 30;
    stall_pct = 30;
  endtask

  task automatic test_noise_texts(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) send_text($urandom_range(0, 10), 40);
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h bv=%0b eor=%0b st=%0b",
                                  out_byte, byte_valid, end_of_result, status));
      end else begin
        want = expected_results.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        if (byte_valid !== want.bv)
          report_mismatch($sformatf("byte_valid %0b, expected %0b", byte_valid, want.bv));
        if (end_of_result !== want.eor)
          report_mismatch($sformatf("end_of_result %0b, expected %0b",
                                    end_of_result, want.eor));
        if (status !== want.st)
          report_mismatch($sformatf("status %0b, expected %0b", status, want.st));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int i;
    for (i = 0; i < 256; i++) sextet_table[i] = -1;
    for (i = 0; i < 64; i++) sextet_table[ALPHABET[i]] = i;
    pend_bits   = '0;
    pend_count  = '0;
    dec_stopped = 1'b0;
    dec_error   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_texts(220);
    test_no_idle_stretch(100);
    test_noise_texts(90);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_top.sv
dv/tb_base64_stream_decoder_top.sv
